/* design/gcpd_pkg.sv */
// Shared types, constants and register codes for the Gray code pixel decoder.
// Used by gcpd_step and gray_code_pixel_decoder_core. No dependencies.

package gcpd_pkg;

   localparam int DEF_MAX_CODE_BITS = 12;
   localparam int DEF_PIXEL_BITS    = 8;

   localparam int ACC_W   = 12;
   localparam int THR_W   = 8;
   localparam int COUNT_W = 4;
   localparam int SIZE_W  = 13;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [THR_W-1:0]   RST_BLACK_THR  = THR_W'(40);
   localparam logic [THR_W-1:0]   RST_WHITE_THR  = THR_W'(5);
   localparam logic [COUNT_W-1:0] RST_COL_COUNT  = COUNT_W'(10);
   localparam logic [COUNT_W-1:0] RST_ROW_COUNT  = COUNT_W'(10);
   localparam logic [SIZE_W-1:0]  RST_PROJ_WIDTH = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0]  RST_PROJ_HEIGHT = SIZE_W'(768);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BLACK_THRESHOLD  = 3'd0,
      CSR_WHITE_THRESHOLD  = 3'd1,
      CSR_COLUMN_BIT_COUNT = 3'd2,
      CSR_ROW_BIT_COUNT    = 3'd3,
      CSR_PROJECTOR_WIDTH  = 3'd4,
      CSR_PROJECTOR_HEIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]   black_threshold;
      logic [THR_W-1:0]   white_threshold;
      logic [COUNT_W-1:0] column_bit_count;
      logic [COUNT_W-1:0] row_bit_count;
      logic [SIZE_W-1:0]  projector_width;
      logic [SIZE_W-1:0]  projector_height;
   } csr_type;

   typedef struct packed {
      logic [ACC_W-1:0] column_acc;
      logic [ACC_W-1:0] row_acc;
      logic             prev_binary_bit;
      logic             error_seen;
      logic             pixel_lit;
   } pixel_state_type;

   typedef struct packed {
      logic [ACC_W-1:0] proj_column;
      logic [ACC_W-1:0] proj_row;
      logic             lit;
      logic             decode_error;
   } result_type;

endpackage

/* design/gcpd_step.sv */
// Next-state and result logic for one intensity pair of a pixel.
// Depends on gcpd_pkg for the state, register and result types.

module gcpd_step #(
   parameter int MAX_CODE_BITS = gcpd_pkg::DEF_MAX_CODE_BITS,
   parameter int PIXEL_BITS    = gcpd_pkg::DEF_PIXEL_BITS,
   parameter int IDX_W         = $clog2(2 * MAX_CODE_BITS + 1)
) (
   input  logic [IDX_W-1:0]          pair_index,
   input  gcpd_pkg::pixel_state_type state_cur,
   input  gcpd_pkg::csr_type         csr,
   input  logic [PIXEL_BITS-1:0]     normal_value,
   input  logic [PIXEL_BITS-1:0]     inverse_value,
   output logic [IDX_W-1:0]          pair_index_next,
   output gcpd_pkg::pixel_state_type state_next,
   output logic                      emit,
   output gcpd_pkg::result_type      result
);
   import gcpd_pkg::*;

   localparam logic [COUNT_W:0] MAX_CNT = (COUNT_W+1)'(MAX_CODE_BITS);

   function automatic logic [IDX_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
      logic [COUNT_W:0] ext;
      ext = {1'b0, c};
      if (ext == '0) begin
         return IDX_W'(1);
      end else if (ext > MAX_CNT) begin
         return IDX_W'(MAX_CODE_BITS);
      end
      return IDX_W'(ext);
   endfunction

   logic [IDX_W-1:0]        ccount;
   logic [IDX_W-1:0]        rcount;
   logic [IDX_W-1:0]        total;
   logic signed [PIXEL_BITS:0] diff;
   logic [PIXEL_BITS-1:0]   mag;
   logic                    gbit;
   logic                    prev_bit;
   logic                    bbit;
   logic                    err;
   pixel_state_type         upd;

   assign ccount = clamp_count(csr.column_bit_count);
   assign rcount = clamp_count(csr.row_bit_count);
   assign total  = ccount + rcount;
   assign diff   = $signed({1'b0, normal_value}) - $signed({1'b0, inverse_value});
   assign gbit   = normal_value > inverse_value;
   assign mag    = gbit ? (normal_value - inverse_value) : (inverse_value - normal_value);
   assign prev_bit = (pair_index == IDX_W'(1) || pair_index == ccount + IDX_W'(1)) ?
                     1'b0 : state_cur.prev_binary_bit;
   assign bbit   = prev_bit ^ gbit;

   always_comb begin
      upd = state_cur;
      if (pair_index == '0) begin
         upd.pixel_lit = diff > $signed({1'b0, PIXEL_BITS'(csr.black_threshold)});
         upd.prev_binary_bit = 1'b0;
      end else begin
         if (mag < PIXEL_BITS'(csr.white_threshold)) begin
            upd.error_seen = 1'b1;
         end
         upd.prev_binary_bit = bbit;
         if (pair_index <= ccount) begin
            upd.column_acc = {state_cur.column_acc[ACC_W-2:0], bbit};
         end else begin
            upd.row_acc = {state_cur.row_acc[ACC_W-2:0], bbit};
         end
      end
   end

   assign emit = pair_index >= total;
   assign err  = upd.error_seen
               || ({1'b0, upd.column_acc} >= SIZE_W'(csr.projector_width))
               || ({1'b0, upd.row_acc} >= SIZE_W'(csr.projector_height));

   always_comb begin
      if (upd.pixel_lit) begin
         result.proj_column  = upd.column_acc;
         result.proj_row     = upd.row_acc;
         result.lit          = 1'b1;
         result.decode_error = err;
      end else begin
         result = '0;
      end
      if (emit) begin
         state_next      = '0;
         pair_index_next = '0;
      end else begin
         state_next      = upd;
         pair_index_next = pair_index + IDX_W'(1);
      end
   end

endmodule

/* design/gray_code_pixel_decoder_core.sv */
// Top level of the Gray code structured-light pixel decoder.
// Depends on gcpd_pkg and instantiates gcpd_step.
//
// Channel | Direction | Handshake           | Content
// req     | in        | req_valid/req_stall | one (normal, inverse) intensity pair
// rsp     | out       | rsp_valid/rsp_stall | column, row, lit and error of one pixel
// csr     | in        | csr_write           | register index and write data
//
// Each pair is latched in an input register and decoded combinationally; a pixel's result lands
// in an output register, and one item is taken per cycle unless the input side is stalled.
// The per-pixel state is updated in the same cycle that a pair leaves the input register.
// Reset restores the register defaults and clears the pixel state.
// A stalled result holds only pairs that would produce a new result; others keep flowing.

module gray_code_pixel_decoder_core #(
   parameter int MAX_CODE_BITS = gcpd_pkg::DEF_MAX_CODE_BITS,
   parameter int PIXEL_BITS    = gcpd_pkg::DEF_PIXEL_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [PIXEL_BITS-1:0]           req_normal_value,
   input  logic [PIXEL_BITS-1:0]           req_inverse_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gcpd_pkg::ACC_W-1:0]      rsp_proj_column,
   output logic [gcpd_pkg::ACC_W-1:0]      rsp_proj_row,
   output logic                            rsp_lit,
   output logic                            rsp_decode_error,
   input  logic                            csr_write,
   input  logic [gcpd_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [gcpd_pkg::CSR_DATA_W-1:0] csr_data
);
   import gcpd_pkg::*;

   localparam int IDX_W = $clog2(2 * MAX_CODE_BITS + 1);

   csr_type                csr_ff;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [PIXEL_BITS-1:0]  s1_normal_ff;
   logic [PIXEL_BITS-1:0]  s1_inverse_ff;
   logic [IDX_W-1:0]       pair_index_ff;
   logic [IDX_W-1:0]       pair_index_in;
   pixel_state_type        state_ff;
   pixel_state_type        state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   result_type             result_ff;
   result_type             result_in;
   logic                   emit;
   logic                   s1_advance;
   logic                   req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.black_threshold  <= RST_BLACK_THR;
         csr_ff.white_threshold  <= RST_WHITE_THR;
         csr_ff.column_bit_count <= RST_COL_COUNT;
         csr_ff.row_bit_count    <= RST_ROW_COUNT;
         csr_ff.projector_width  <= RST_PROJ_WIDTH;
         csr_ff.projector_height <= RST_PROJ_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLACK_THRESHOLD:  csr_ff.black_threshold  <= csr_data[THR_W-1:0];
            CSR_WHITE_THRESHOLD:  csr_ff.white_threshold  <= csr_data[THR_W-1:0];
            CSR_COLUMN_BIT_COUNT: csr_ff.column_bit_count <= csr_data[COUNT_W-1:0];
            CSR_ROW_BIT_COUNT:    csr_ff.row_bit_count    <= csr_data[COUNT_W-1:0];
            CSR_PROJECTOR_WIDTH:  csr_ff.projector_width  <= csr_data[SIZE_W-1:0];
            CSR_PROJECTOR_HEIGHT: csr_ff.projector_height <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   gcpd_step #(
      .MAX_CODE_BITS(MAX_CODE_BITS),
      .PIXEL_BITS   (PIXEL_BITS),
      .IDX_W        (IDX_W)
   ) u_step (
      .pair_index     (pair_index_ff),
      .state_cur      (state_ff),
      .csr            (csr_ff),
      .normal_value   (s1_normal_ff),
      .inverse_value  (s1_inverse_ff),
      .pair_index_next(pair_index_in),
      .state_next     (state_in),
      .emit           (emit),
      .result         (result_in)
   );

   assign s1_advance  = s1_valid_ff && (!emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_advance;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = (s1_advance && emit) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pair_index_ff <= '0;
         state_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            pair_index_ff <= pair_index_in;
            state_ff      <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_normal_ff  <= req_normal_value;
         s1_inverse_ff <= req_inverse_value;
      end
      if (s1_advance && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_proj_column  = result_ff.proj_column;
   assign rsp_proj_row     = result_ff.proj_row;
   assign rsp_lit          = result_ff.lit;
   assign rsp_decode_error = result_ff.decode_error;

   // A shadowed pixel never reports coordinates or an error.
   a_shadow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lit |-> rsp_proj_column == '0 && rsp_proj_row == '0
                                && !rsp_decode_error)
      else $error("shadowed pixel reported nonzero fields");

   // The pair position never runs past the last possible pair.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      pair_index_ff <= IDX_W'(2 * MAX_CODE_BITS))
      else $error("pair index out of range");

   // Emitting a result restarts the pixel.
   a_emit_restart: assert property (@(posedge clock) disable iff (reset)
      s1_advance && emit |=> pair_index_ff == '0 && state_ff == '0 && rsp_valid)
      else $error("pixel state not cleared after result");

   // The input side only stalls when a decoded item is blocked by the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && emit && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for gray_code_pixel_decoder_core: drives intensity pairs and
// register writes, predicts every pixel result and compares it with the block's output.
// Depends on gcpd_pkg and gray_code_pixel_decoder_core.

module tb_top;
   import gcpd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   class pixel_decode_board;
      logic [THR_W-1:0]   black_thr;
      logic [THR_W-1:0]   white_thr;
      logic [COUNT_W-1:0] col_bits;
      logic [COUNT_W-1:0] row_bits;
      logic [SIZE_W-1:0]  proj_w;
      logic [SIZE_W-1:0]  proj_h;
      int unsigned        pair_pos;
      logic [ACC_W-1:0]   col_acc;
      logic [ACC_W-1:0]   row_acc;
      logic               prev_bit;
      logic               err_seen;
      logic               lit_seen;
      result_type         expected_pixels[$];
      int                 bad_pixels;
      int                 pixels_seen;

      function new();
         black_thr = RST_BLACK_THR;
         white_thr = RST_WHITE_THR;
         col_bits = RST_COL_COUNT;
         row_bits = RST_ROW_COUNT;
         proj_w = RST_PROJ_WIDTH;
         proj_h = RST_PROJ_HEIGHT;
         bad_pixels = 0;
         pixels_seen = 0;
         clear_pixel();
      endfunction

      function void clear_pixel();
         pair_pos = 0;
         col_acc = '0;
         row_acc = '0;
         prev_bit = 1'b0;
         err_seen = 1'b0;
         lit_seen = 1'b0;
      endfunction

      // Counts outside one to twelve are pinned to the nearest end.
      function int unsigned used_bits(input logic [COUNT_W-1:0] count);
         if (count == 0) return 1;
         if (count > DEF_MAX_CODE_BITS) return DEF_MAX_CODE_BITS;
         return count;
      endfunction

      function void set_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_BLACK_THRESHOLD:  black_thr = value[THR_W-1:0];
            CSR_WHITE_THRESHOLD:  white_thr = value[THR_W-1:0];
            CSR_COLUMN_BIT_COUNT: col_bits = value[COUNT_W-1:0];
            CSR_ROW_BIT_COUNT:    row_bits = value[COUNT_W-1:0];
            CSR_PROJECTOR_WIDTH:  proj_w = value[SIZE_W-1:0];
            CSR_PROJECTOR_HEIGHT: proj_h = value[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pair(input logic [7:0] nv, input logic [7:0] iv);
         int          diff;
         int unsigned mag;
         int unsigned ccount;
         int unsigned rcount;
         logic        bbit;
         result_type  want;
         ccount = used_bits(col_bits);
         rcount = used_bits(row_bits);
         diff = int'(nv) - int'(iv);
         mag = (diff < 0) ? -diff : diff;
         if (pair_pos == 0) begin
            lit_seen = (diff > int'(black_thr));
            prev_bit = 1'b0;
         end else begin
            if (pair_pos == 1 || pair_pos == ccount + 1) prev_bit = 1'b0;
            if (mag < white_thr) err_seen = 1'b1;
            bbit = prev_bit ^ (nv > iv);
            prev_bit = bbit;
            if (pair_pos <= ccount) col_acc = {col_acc[ACC_W-2:0], bbit};
            else row_acc = {row_acc[ACC_W-2:0], bbit};
         end
         if (pair_pos >= ccount + rcount) begin
            want = '0;
            if (lit_seen) begin
               want.proj_column = col_acc;
               want.proj_row = row_acc;
               want.lit = 1'b1;
               want.decode_error = err_seen || (col_acc >= proj_w) || (row_acc >= proj_h);
            end
            expected_pixels = {expected_pixels, want};
            clear_pixel();
         end else begin
            pair_pos++;
         end
      endfunction

      function void check_pixel(input result_type got);
         result_type want;
         pixels_seen++;
         if (expected_pixels.size() == 0) begin
            $display("%0t: result with none expected: col=%0d row=%0d lit=%0b err=%0b",
                     $time, got.proj_column, got.proj_row, got.lit, got.decode_error);
            bad_pixels++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want) begin
            $display({"%0t: expected col=%0d row=%0d lit=%0b err=%0b, ",
                      "got col=%0d row=%0d lit=%0b err=%0b"},
                     $time, want.proj_column, want.proj_row, want.lit, want.decode_error,
                     got.proj_column, got.proj_row, got.lit, got.decode_error);
            bad_pixels++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_normal_value = '0;
   logic [7:0]            req_inverse_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ACC_W-1:0]      rsp_proj_column;
   logic [ACC_W-1:0]      rsp_proj_row;
   logic                  rsp_lit;
   logic                  rsp_decode_error;
   logic                  csr_write = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = CSR_BLACK_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pixel_decode_board board = new();
   int                gap_pct = 0;
   int                stall_pct = 0;
   int                pairs_sent = 0;
   int                cycles = 0;

   gray_code_pixel_decoder_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_normal_value  (req_normal_value),
      .req_inverse_value (req_inverse_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_proj_column   (rsp_proj_column),
      .rsp_proj_row      (rsp_proj_row),
      .rsp_lit           (rsp_lit),
      .rsp_decode_error  (rsp_decode_error),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_pixel({rsp_proj_column, rsp_proj_row, rsp_lit, rsp_decode_error});
      if (!reset && req_valid && !req_stall)
         board.note_pair(req_normal_value, req_inverse_value);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_pair(input int unsigned nv, input int unsigned iv);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_normal_value <= 8'(nv);
      req_inverse_value <= 8'(iv);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pairs_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_pixels.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      board.set_register(idx, CSR_DATA_W'(value));
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 75) return COUNT_W'($urandom_range(1, 5));
      if (roll < 88) return COUNT_W'($urandom_range(6, 12));
      return roll[0] ? 4'd0 : 4'($urandom_range(13, 15));
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size(input logic [COUNT_W-1:0] count);
      int unsigned span;
      span = 1 << board.used_bits(count);
      if ($urandom_range(99) < 85) return SIZE_W'($urandom_range(0, span + 1));
      return SIZE_W'($urandom_range(0, 8191));
   endfunction

   task automatic apply_settings(input int unsigned which);
      logic [THR_W-1:0]   blk;
      logic [THR_W-1:0]   wht;
      logic [COUNT_W-1:0] cc;
      logic [COUNT_W-1:0] rc;
      logic [SIZE_W-1:0]  pw;
      logic [SIZE_W-1:0]  ph;
      case (which)
         0: begin
            blk = 8'd0; wht = 8'd0; cc = 4'd12; rc = 4'd12; pw = 13'd4096; ph = 13'd4096;
         end
         1: begin
            blk = 8'd255; wht = 8'd255; cc = 4'd0; rc = 4'd15; pw = 13'd0; ph = 13'd8191;
         end
         2: begin
            blk = 8'd1; wht = 8'd1; cc = 4'd13; rc = 4'd1; pw = 13'd1; ph = 13'd1;
         end
         default: begin
            blk = THR_W'($urandom_range(0, 100));
            wht = THR_W'($urandom_range(0, 40));
            cc = pick_count();
            rc = pick_count();
            pw = pick_size(cc);
            ph = pick_size(rc);
         end
      endcase
      write_register(CSR_BLACK_THRESHOLD, blk);
      write_register(CSR_WHITE_THRESHOLD, wht);
      write_register(CSR_COLUMN_BIT_COUNT, cc);
      write_register(CSR_ROW_BIT_COUNT, rc);
      write_register(CSR_PROJECTOR_WIDTH, pw);
      write_register(CSR_PROJECTOR_HEIGHT, ph);
   endtask

   // A well-formed pixel encodes a chosen column and row; a few pixels are pure noise.
   task automatic send_pixel();
      int unsigned cb;
      int unsigned rb;
      int unsigned col;
      int unsigned row;
      logic [ACC_W-1:0] gcol;
      logic [ACC_W-1:0] grow;
      logic [7:0] lo;
      logic [7:0] hi;
      logic code;
      bit noise;
      int j;
      cb = board.used_bits(board.col_bits);
      rb = board.used_bits(board.row_bits);
      noise = ($urandom_range(99) < 10);
      col = $urandom_range(0, (1 << cb) - 1);
      row = $urandom_range(0, (1 << rb) - 1);
      gcol = ACC_W'(col ^ (col >> 1));
      grow = ACC_W'(row ^ (row >> 1));
      if (noise) begin
         send_pair($urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
         lo = 8'($urandom_range(0, 100));
         send_pair($urandom_range(lo, 255), lo);
      end
      for (j = 0; j < cb + rb; j++) begin
         code = (j < cb) ? gcol[cb-1-j] : grow[rb-1-(j-cb)];
         if (noise || $urandom_range(99) < 8) begin
            send_pair($urandom_range(0, 255), $urandom_range(0, 255));
         end else begin
            lo = 8'($urandom_range(0, 200));
            hi = 8'(lo + $urandom_range(0, 55));
            if (code) send_pair(hi, lo);
            else send_pair(lo, hi);
         end
      end
   endtask

   initial begin
      int unsigned setting_no;
      int phase;
      int span;
      setting_no = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 25;
      stall_pct = 72;

      write_register(CSR_BLACK_THRESHOLD, 40);
      write_register(CSR_WHITE_THRESHOLD, 5);
      write_register(CSR_COLUMN_BIT_COUNT, 1);
      write_register(CSR_ROW_BIT_COUNT, 1);
      write_register(CSR_PROJECTOR_WIDTH, 2);
      write_register(CSR_PROJECTOR_HEIGHT, 2);
      send_pair(255, 0);
      send_pair(200, 10);
      send_pair(10, 200);
      send_pair(40, 0);
      send_pair(0, 255);
      send_pair(255, 0);
      send_pair(41, 0);
      send_pair(0, 0);
      send_pair(255, 255);
      send_pair(0, 255);
      send_pair(128, 128);
      send_pair(1, 0);
      send_pair(255, 0);
      send_pair(104, 100);
      send_pair(100, 105);
      settle();
      write_register(CSR_PROJECTOR_WIDTH, 0);
      send_pair(255, 0);
      send_pair(0, 255);
      send_pair(0, 255);
      settle();
      // Start a pixel with wider counts, then shrink the counts while it is part way through its run.
      write_register(CSR_COLUMN_BIT_COUNT, 2);
      write_register(CSR_ROW_BIT_COUNT, 2);
      send_pair(255, 0);
      send_pair(255, 0);
      send_pair(0, 255);
      settle();
      write_register(CSR_COLUMN_BIT_COUNT, 1);
      write_register(CSR_ROW_BIT_COUNT, 1);
      send_pair(0, 255);

      for (phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 25 : (phase == 1) ? 72 : 0;
         stall_pct = (phase == 0) ? 72 : (phase == 1) ? 25 : 0;
         while (pairs_sent < (phase + 1) * 140 || board.pixels_seen < (phase + 1) * 16) begin
            settle();
            apply_settings(setting_no);
            setting_no++;
            span = board.used_bits(board.col_bits) + board.used_bits(board.row_bits);
            repeat ((span > 12) ? $urandom_range(1, 2) : $urandom_range(4, 10)) send_pixel();
            if ($urandom_range(99) < 30)
               repeat ($urandom_range(1, span))
                  send_pair($urandom_range(0, 255), $urandom_range(0, 255));
         end
      end
      settle();

      if (board.bad_pixels == 0 && board.expected_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
